@@ design/clg_pkg.sv @@
// Package for the core count load governor.
// Types, widths, reset values and codes shared by the governor's files.
// No dependencies.
package clg_pkg;

  // Parameter defaults
  localparam int WINDOW_SLOTS_DEF = 16;
  localparam int CORES_DEF        = 4;
  localparam int TIME_BITS_DEF    = 32;

  // Field widths
  localparam int OP_W       = 2;
  localparam int TASKS_W    = 8;
  localparam int ONLINE_W   = 3;
  localparam int TARGET_W   = 3;
  localparam int AVG_W      = 15;
  localparam int SAMPLE_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PERIODS_W  = 5;
  localparam int INTERVAL_W = 4;
  localparam int THR_W      = 10;
  localparam int LOAD_W     = 14;

  localparam int SAMPLE_SCALE = 100;
  localparam int MAX_SAMPLE   = 255 * SAMPLE_SCALE;

  // Register reset values
  localparam logic                  ENABLE_RST   = 1'b0;
  localparam logic [PERIODS_W-1:0]  WINDOW_RST   = 5'd6;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 4'd4;
  localparam logic [THR_W-1:0]      ALL_ON_RST   = 10'd333;
  localparam logic [THR_W-1:0]      ONE_ON_RST   = 10'd233;
  localparam logic [THR_W-1:0]      ONE_OFF_RST  = 10'd133;
  localparam logic [THR_W-1:0]      HOLD_RST     = 10'd100;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_SCREEN_OFF = 2'd1,
    OP_SCREEN_ON  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_WINDOW       = 3'd1,
    CFG_INTERVAL     = 3'd2,
    CFG_ALL_ON       = 3'd3,
    CFG_ONE_ON       = 3'd4,
    CFG_ONE_OFF      = 3'd5,
    CFG_OFFLINE_HOLD = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCREEN,
    ST_CHECK,
    ST_MERGE,
    ST_DIV,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [TASKS_W-1:0]  running_tasks;
    logic [ONLINE_W-1:0] online_cores;
  } in_item_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_cores;
    logic                change_request;
    logic                decision_made;
    logic [AVG_W-1:0]    average_load;
    logic                stopped;
  } out_item_t;

  // Window memory control
  typedef struct packed {
    logic clear;
    logic advance;
    logic commit;
  } win_ctrl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Width of the running window sum for a given slot count
  function automatic int sum_width(input int slots);
    return $clog2(slots * MAX_SAMPLE + 1);
  endfunction

endpackage

@@ design/clg_stream_if.sv @@
// Valid/ready stream interface for the governor's item and result channels.
// Payload type is a parameter; no package dependency.
interface clg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/clg_window.sv @@
// Sample ring memory with valid bits and running sum.
// Depends on clg_pkg.
module clg_window #(
  parameter int  WINDOW_SLOTS = clg_pkg::WINDOW_SLOTS_DEF,
  localparam int SLOT_W = $clog2(WINDOW_SLOTS),
  localparam int PER_W  = $clog2(WINDOW_SLOTS + 1),
  localparam int SUM_W  = clg_pkg::sum_width(WINDOW_SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clg_pkg::win_ctrl_t            ctrl_i,
  input  logic [PER_W-1:0]              periods_i,
  input  logic [clg_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [SUM_W-1:0]              sum_o,
  output logic [SUM_W-1:0]              sum_next_o
);

  logic [clg_pkg::SAMPLE_W-1:0] sample_mem [WINDOW_SLOTS];
  logic [clg_pkg::SAMPLE_W-1:0] rdata_q;
  logic [clg_pkg::SAMPLE_W-1:0] old_sample;
  logic [WINDOW_SLOTS-1:0]      valid_q;
  logic [SLOT_W-1:0]            slot_q;
  logic [SLOT_W-1:0]            slot_nxt;
  logic [SUM_W-1:0]             sum_q;

  // Ring advance wraps at the active window length
  always_comb begin
    if (int'(slot_q) + 1 >= int'(periods_i)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_q + SLOT_W'(1);
    end
  end

  // Never-written slots read as zero
  assign old_sample = valid_q[slot_q] ? rdata_q : '0;
  assign sum_next_o = sum_q - SUM_W'(old_sample) + SUM_W'(sample_i);
  assign sum_o      = sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      sample_mem[slot_q] <= sample_i;
    end
    if (ctrl_i.advance) begin
      rdata_q <= sample_mem[slot_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
    end else if (ctrl_i.clear) begin
      valid_q <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
    end else begin
      if (ctrl_i.advance) begin
        slot_q <= slot_nxt;
      end
      if (ctrl_i.commit) begin
        valid_q[slot_q] <= 1'b1;
        sum_q           <= sum_next_o;
      end
    end
  end

endmodule

@@ design/clg_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on clg_pkg.
module clg_divider #(
  parameter int  DIVIDEND_W = 19,
  parameter int  DIVISOR_W  = 5,
  localparam int CNT_W = $clog2(DIVIDEND_W)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DIVIDEND_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0]    divisor_i,
  output logic [DIVIDEND_W-1:0]   quotient_o,
  output clg_pkg::div_status_t    status_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      count_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;
  logic                  last;

  assign rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign last     = count_q == CNT_W'(DIVIDEND_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q  <= 1'b1;
        count_q <= '0;
      end else if (busy_q) begin
        count_q <= count_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ design/core_count_load_governor.sv @@
// Core count load governor: top level with control sequencer and state registers.
// Depends on clg_pkg, clg_stream_if, clg_window and clg_divider.
//
// One transaction in, one result out. A tick passes through the PREP and CHECK
// states, and MERGE when it samples the window; a screen event passes through
// PREP, and SCREEN for a screen-on while enabled, before OUT. A decision tick
// adds DIV and DECIDE; in DIV the bit-serial divider forms the window average
// one quotient bit per cycle. The load samples live in a ring memory with a
// registered read, issued in CHECK: the old sample of the slot being
// replaced is read, subtracted from the running sum and overwritten in the next
// cycle. Per-slot valid bits make the window read as zero after reset or a
// window_periods write, so no clearing pass is needed. The result sits in an
// output register, so the next transaction is taken while it waits. Register
// writes go through the plain write port and are expected only while no
// transaction is in flight.
module core_count_load_governor #(
  parameter int WINDOW_SLOTS = clg_pkg::WINDOW_SLOTS_DEF,
  parameter int CORES        = clg_pkg::CORES_DEF,
  parameter int TIME_BITS    = clg_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [clg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  clg_stream_if.sink                      item_i,
  clg_stream_if.source                    result_o
);

  localparam int PER_W = $clog2(WINDOW_SLOTS + 1);
  localparam int SUM_W = clg_pkg::sum_width(WINDOW_SLOTS);
  localparam int CNT_W = $clog2(CORES + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // a strictly later than b, modulo the time width
  function automatic logic later(input time_t a, input time_t b);
    time_t d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  // window length saturated to 2..WINDOW_SLOTS
  function automatic logic [PER_W-1:0] clamp_periods(
    input logic [clg_pkg::PERIODS_W-1:0] w
  );
    int v;
    v = int'(w);
    if (v < 2) v = 2;
    if (v > WINDOW_SLOTS) v = WINDOW_SLOTS;
    return PER_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  clg_pkg::state_e state_q, state_d;
  clg_pkg::in_item_t in_q, in_d;

  // configuration
  logic                             enable_q, enable_d;
  logic [clg_pkg::PERIODS_W-1:0]    wp_q, wp_d;
  logic [clg_pkg::INTERVAL_W-1:0]   interval_q, interval_d;
  logic [clg_pkg::THR_W-1:0]        all_on_q, all_on_d;
  logic [clg_pkg::THR_W-1:0]        one_on_q, one_on_d;
  logic [clg_pkg::THR_W-1:0]        one_off_q, one_off_d;
  logic [clg_pkg::THR_W-1:0]        hold_cfg_q, hold_cfg_d;

  // governor state
  time_t                            now_q, now_d;
  time_t                            next_q, next_d;
  time_t                            release_q, release_d;
  logic [CNT_W-1:0]                 target_q, target_d;
  logic                             hold_online_q, hold_online_d;
  logic                             hold_offline_q, hold_offline_d;
  logic                             halted_q, halted_d;
  logic [clg_pkg::AVG_W-1:0]        last_avg_q, last_avg_d;

  // per-transaction working registers
  time_t                            win_start_q, win_start_d;
  time_t                            hold_t_q, hold_t_d;
  logic                             change_q, change_d;
  logic                             decided_q, decided_d;
  logic                             due_q, due_d;
  logic [clg_pkg::SAMPLE_W-1:0]     s_q, s_d;
  logic [clg_pkg::LOAD_W-1:0]       off_load_q, off_load_d;
  logic [clg_pkg::LOAD_W-1:0]       off_plus_q, off_plus_d;
  logic [clg_pkg::LOAD_W-1:0]       on_load_q, on_load_d;

  // output register
  logic                             out_valid_q, out_valid_d;
  clg_pkg::out_item_t               out_data_q, out_data_d;

  // datapath links
  logic [PER_W-1:0]                 eff_p;
  logic [clg_pkg::INTERVAL_W-1:0]   iv;
  logic                             sample_go;
  logic                             out_free;
  clg_pkg::win_ctrl_t               win_ctrl;
  logic [SUM_W-1:0]                 win_sum;
  logic [SUM_W-1:0]                 win_sum_next;
  logic                             div_start;
  logic [SUM_W-1:0]                 div_quo;
  clg_pkg::div_status_t             div_st;

  assign eff_p     = clamp_periods(wp_q);
  assign iv        = (interval_q == '0) ? clg_pkg::INTERVAL_W'(1) : interval_q;
  // a tick samples once the window start time has been reached, unless halted
  assign sample_go = !halted_q && !later(win_start_q, now_q);
  assign out_free  = !out_valid_q || result_o.ready;

  assign item_i.ready   = (state_q == clg_pkg::ST_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  clg_window #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (win_ctrl),
    .periods_i  (eff_p),
    .sample_i   (s_q),
    .sum_o      (win_sum),
    .sum_next_o (win_sum_next)
  );

  clg_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (PER_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (win_sum_next),
    .divisor_i  (eff_p),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clg_pkg::ST_IDLE: begin
        if (item_i.valid) state_d = clg_pkg::ST_PREP;
      end
      clg_pkg::ST_PREP: begin
        case (clg_pkg::op_e'(in_q.operation))
          clg_pkg::OP_TICK:      state_d = clg_pkg::ST_CHECK;
          clg_pkg::OP_SCREEN_ON: state_d = enable_q ? clg_pkg::ST_SCREEN : clg_pkg::ST_OUT;
          default:               state_d = clg_pkg::ST_OUT;
        endcase
      end
      clg_pkg::ST_SCREEN: state_d = clg_pkg::ST_OUT;
      clg_pkg::ST_CHECK:  state_d = sample_go ? clg_pkg::ST_MERGE : clg_pkg::ST_OUT;
      clg_pkg::ST_MERGE:  state_d = due_q ? clg_pkg::ST_DIV : clg_pkg::ST_OUT;
      clg_pkg::ST_DIV: begin
        if (div_st.done) state_d = clg_pkg::ST_DECIDE;
      end
      clg_pkg::ST_DECIDE: state_d = clg_pkg::ST_OUT;
      clg_pkg::ST_OUT: begin
        if (out_free) state_d = clg_pkg::ST_IDLE;
      end
      default: state_d = clg_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [CNT_W:0]            t;
    logic                      done;
    logic [clg_pkg::AVG_W-1:0] avg;
    time_t                     cfg_t;

    in_d           = in_q;
    enable_d       = enable_q;
    wp_d           = wp_q;
    interval_d     = interval_q;
    all_on_d       = all_on_q;
    one_on_d       = one_on_q;
    one_off_d      = one_off_q;
    hold_cfg_d     = hold_cfg_q;
    now_d          = now_q;
    next_d         = next_q;
    release_d      = release_q;
    target_d       = target_q;
    hold_online_d  = hold_online_q;
    hold_offline_d = hold_offline_q;
    halted_d       = halted_q;
    last_avg_d     = last_avg_q;
    win_start_d    = win_start_q;
    hold_t_d       = hold_t_q;
    change_d       = change_q;
    decided_d      = decided_q;
    due_d          = due_q;
    s_d            = s_q;
    off_load_d     = off_load_q;
    off_plus_d     = off_plus_q;
    on_load_d      = on_load_q;
    out_valid_d    = out_valid_q && !result_o.ready;
    out_data_d     = out_data_q;
    win_ctrl       = '0;
    div_start      = 1'b0;
    t              = '0;
    done           = 1'b0;
    avg            = div_quo[clg_pkg::AVG_W-1:0];
    cfg_t          = '0;

    unique case (state_q)
      clg_pkg::ST_IDLE: begin
        if (item_i.valid) in_d = item_i.data;
      end

      clg_pkg::ST_PREP: begin
        change_d  = 1'b0;
        decided_d = 1'b0;
        hold_t_d  = now_q + time_t'(hold_cfg_q);
        case (clg_pkg::op_e'(in_q.operation))
          clg_pkg::OP_TICK: begin
            now_d       = now_q + time_t'(1);
            win_start_d = next_q - time_t'(eff_p);
          end
          clg_pkg::OP_SCREEN_OFF: begin
            if (enable_q) hold_online_d = 1'b1;
          end
          default: ;
        endcase
      end

      // screen on: all cores, offlining held
      clg_pkg::ST_SCREEN: begin
        hold_online_d  = 1'b0;
        hold_offline_d = 1'b1;
        halted_d       = 1'b0;
        target_d       = CNT_W'(CORES);
        if (later(hold_t_q, release_q)) release_d = hold_t_q;
        if (later(hold_t_q, next_q)) next_d = hold_t_q;
        change_d = CORES != int'(in_q.online_cores);
      end

      clg_pkg::ST_CHECK: begin
        if (hold_offline_q && !later(release_q, now_q)) hold_offline_d = 1'b0;
        due_d = !later(next_q, now_q);
        if (sample_go) begin
          win_ctrl.advance = 1'b1;
          s_d = clg_pkg::SAMPLE_W'(in_q.running_tasks) *
                clg_pkg::SAMPLE_W'(clg_pkg::SAMPLE_SCALE);
        end
      end

      clg_pkg::ST_MERGE: begin
        win_ctrl.commit = 1'b1;
        if (due_q) begin
          div_start  = 1'b1;
          next_d     = next_q + time_t'(iv);
          hold_t_d   = now_q + time_t'(hold_cfg_q);
          off_load_d = clg_pkg::LOAD_W'(one_off_q) * clg_pkg::LOAD_W'(in_q.online_cores);
          off_plus_d = clg_pkg::LOAD_W'(one_off_q) *
                       (clg_pkg::LOAD_W'(in_q.online_cores) + clg_pkg::LOAD_W'(1));
          on_load_d  = clg_pkg::LOAD_W'(one_on_q) * clg_pkg::LOAD_W'(in_q.online_cores);
        end
      end

      clg_pkg::ST_DIV: ;

      clg_pkg::ST_DECIDE: begin
        t = {1'b0, target_q};
        last_avg_d = avg;
        decided_d  = 1'b1;
        if (!hold_online_q) begin
          if (avg >= all_on_q) begin
            t              = (CNT_W+1)'(CORES);
            hold_offline_d = 1'b1;
            if (later(hold_t_q, release_q)) release_d = hold_t_q;
            if (later(hold_t_q, next_q)) next_d = hold_t_q;
            done = 1'b1;
          end else if (s_q >= on_load_q && avg >= off_plus_q) begin
            t    = t + (CNT_W+1)'(1);
            done = 1'b1;
          end
        end else begin
          if (avg >= all_on_q) begin
            t    = t + (CNT_W+1)'(1);
            done = 1'b1;
          end else if (int'(in_q.online_cores) == 1) begin
            halted_d = 1'b1;
          end
        end
        // lowering saturates at zero before the clamp
        if (!done && !hold_offline_q && avg < off_load_q && t != '0) begin
          t = t - (CNT_W+1)'(1);
        end
        if (t > (CNT_W+1)'(CORES)) t = (CNT_W+1)'(CORES);
        if (t == '0) t = (CNT_W+1)'(1);
        target_d = t[CNT_W-1:0];
        change_d = int'(t) != int'(in_q.online_cores);
      end

      clg_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.target_cores    = clg_pkg::TARGET_W'(target_q);
          out_data_d.change_request  = change_q;
          out_data_d.decision_made   = decided_q;
          out_data_d.average_load    = last_avg_q;
          out_data_d.stopped         = halted_q && hold_online_q;
        end
      end

      default: ;
    endcase

    // register writes, to be made only while idle; the block does not enforce this
    if (cfg_we_i) begin
      unique case (clg_pkg::cfg_reg_e'(cfg_index_i))
        clg_pkg::CFG_ENABLE: begin
          enable_d       = cfg_data_i[0];
          hold_online_d  = 1'b0;
          hold_offline_d = 1'b0;
          if (cfg_data_i[0]) begin
            halted_d = 1'b0;
            next_d   = now_q + time_t'(eff_p);
          end else begin
            halted_d = 1'b1;
          end
        end
        clg_pkg::CFG_WINDOW: begin
          wp_d           = cfg_data_i[clg_pkg::PERIODS_W-1:0];
          win_ctrl.clear = 1'b1;
          cfg_t = now_q + time_t'(clamp_periods(cfg_data_i[clg_pkg::PERIODS_W-1:0]));
          if (later(cfg_t, next_q)) next_d = cfg_t;
        end
        clg_pkg::CFG_INTERVAL:     interval_d = cfg_data_i[clg_pkg::INTERVAL_W-1:0];
        clg_pkg::CFG_ALL_ON:       all_on_d   = cfg_data_i[clg_pkg::THR_W-1:0];
        clg_pkg::CFG_ONE_ON:       one_on_d   = cfg_data_i[clg_pkg::THR_W-1:0];
        clg_pkg::CFG_ONE_OFF:      one_off_d  = cfg_data_i[clg_pkg::THR_W-1:0];
        clg_pkg::CFG_OFFLINE_HOLD: hold_cfg_d = cfg_data_i[clg_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= clg_pkg::ST_IDLE;
      enable_q       <= clg_pkg::ENABLE_RST;
      wp_q           <= clg_pkg::WINDOW_RST;
      interval_q     <= clg_pkg::INTERVAL_RST;
      all_on_q       <= clg_pkg::ALL_ON_RST;
      one_on_q       <= clg_pkg::ONE_ON_RST;
      one_off_q      <= clg_pkg::ONE_OFF_RST;
      hold_cfg_q     <= clg_pkg::HOLD_RST;
      now_q          <= '0;
      next_q         <= '0;
      release_q      <= '0;
      target_q       <= '0;
      hold_online_q  <= 1'b0;
      hold_offline_q <= 1'b0;
      halted_q       <= 1'b1;
      last_avg_q     <= '0;
      change_q       <= 1'b0;
      decided_q      <= 1'b0;
      due_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      enable_q       <= enable_d;
      wp_q           <= wp_d;
      interval_q     <= interval_d;
      all_on_q       <= all_on_d;
      one_on_q       <= one_on_d;
      one_off_q      <= one_off_d;
      hold_cfg_q     <= hold_cfg_d;
      now_q          <= now_d;
      next_q         <= next_d;
      release_q      <= release_d;
      target_q       <= target_d;
      hold_online_q  <= hold_online_d;
      hold_offline_q <= hold_offline_d;
      halted_q       <= halted_d;
      last_avg_q     <= last_avg_d;
      change_q       <= change_d;
      decided_q      <= decided_d;
      due_q          <= due_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    win_start_q <= win_start_d;
    hold_t_q    <= hold_t_d;
    s_q         <= s_d;
    off_load_q  <= off_load_d;
    off_plus_q  <= off_plus_d;
    on_load_q   <= on_load_d;
    out_data_q  <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("second transaction taken while one is in flight");

  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_decide_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clg_pkg::ST_DECIDE |-> $past(div_st.done))
    else $error("decision taken without a finished average");

  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clg_pkg::ST_DECIDE |=> (target_q != '0) && (int'(target_q) <= CORES))
    else $error("target core count out of range after decision");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_sum <= SUM_W'(eff_p) * SUM_W'(clg_pkg::MAX_SAMPLE))
    else $error("window sum exceeds window length times largest sample");

endmodule
